>>> hw/rtl/text_console_cursor_engine_core_assert.svh
// assertion helpers for the text console cursor engine checker
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_CORE_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define TCCE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that holds whenever a result request is shown
`define TCCE_ASSERT_VALID(lbl, cond, msg) \
	`TCCE_ASSERT(lbl, m_tvalid |-> (cond), msg)

`endif

>>> hw/rtl/tcce_pkg.sv
package tcce_pkg;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_SCROLL = 2'd1,
		KIND_CURSOR = 2'd2
	} kind_t;

	localparam logic FUNC_PUT  = 1'b0;
	localparam logic FUNC_MARK = 1'b1;

	localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
	localparam logic [7:0] CHAR_TAB       = 8'd9;
	localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
	localparam logic [7:0] CHAR_SPACE     = 8'd32;

	localparam int TAB_BITS = 2;
	localparam int TAB_STOP = 1 << TAB_BITS;

	localparam logic [7:0] COLOR_RESET = 8'd2;
	localparam int MAX_RESULTS = 3;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  cell_row;
		logic [6:0]  cell_column;
		logic [15:0] cell_value;
		logic [10:0] cursor_position;
		logic        last;
	} res_t;

endpackage

>>> hw/rtl/tcce_step.sv
module tcce_step #(
	parameter int SCREEN_WIDTH  = 80,
	parameter int SCREEN_HEIGHT = 25,
	parameter int RW = $clog2(SCREEN_HEIGHT + 1),
	parameter int CW = $clog2(SCREEN_WIDTH + 1)
) (
	input  logic                   func,
	input  logic [7:0]             char_code,
	input  logic [7:0]             text_color,
	input  logic [RW-1:0]          row,
	input  logic [CW-1:0]          column,
	input  logic [10:0]            back_limit,
	output logic [RW-1:0]          row_next,
	output logic [CW-1:0]          column_next,
	output logic [10:0]            back_limit_next,
	output logic [1:0]             res_count,
	output tcce_pkg::res_t         res [tcce_pkg::MAX_RESULTS]
);
	import tcce_pkg::*;

	localparam logic [RW-1:0] H_C    = RW'(SCREEN_HEIGHT);
	localparam logic [RW-1:0] HM1_C  = RW'(SCREEN_HEIGHT - 1);
	localparam logic [CW-1:0] W_C    = CW'(SCREEN_WIDTH);
	localparam logic [CW:0]   W_EXT  = (CW+1)'(SCREEN_WIDTH);
	localparam logic [CW:0]   TAB_EXT = (CW+1)'(TAB_STOP);

	function automatic logic [10:0] cur_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
		logic [31:0] p;
		p = 32'(r) * 32'(SCREEN_WIDTH) + 32'(c);
		return p[10:0];
	endfunction

	function automatic res_t mk_res(input kind_t k, input logic [RW-1:0] r,
		input logic [CW-1:0] c, input logic [15:0] v, input logic [10:0] cur);
		res_t x;
		x.kind            = k;
		x.cell_row        = 5'(r);
		x.cell_column     = 7'(c);
		x.cell_value      = v;
		x.cursor_position = cur;
		x.last            = 1'b0;
		return x;
	endfunction

	logic [RW-1:0] nrow;
	logic [CW-1:0] ncol;
	logic [CW:0]   tab_c;
	logic [1:0]    n;

	always_comb begin
		nrow            = row;
		ncol            = column;
		back_limit_next = back_limit;
		n               = 2'd0;
		tab_c           = '0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res[i] = '0;
		end
		if (func == FUNC_MARK) begin
			back_limit_next = cur_of(row, column);
		end else begin
			// pending wrap, then pending scroll
			if (column >= W_C) begin
				ncol = '0;
				nrow = row + RW'(1);
			end
			if (nrow >= H_C) begin
				nrow   = HM1_C;
				ncol   = '0;
				res[0] = mk_res(KIND_SCROLL, '0, '0, '0, cur_of(HM1_C, '0));
				n      = 2'd1;
			end
			unique case (char_code)
				CHAR_NEWLINE: begin
					ncol   = '0;
					nrow   = nrow + RW'(1);
					res[n] = mk_res(KIND_CURSOR, '0, '0, '0, cur_of(nrow, ncol));
					n      = n + 2'd1;
				end
				CHAR_TAB: begin
					tab_c = {1'b0, ncol[CW-1:TAB_BITS], TAB_BITS'(0)} + TAB_EXT;
					ncol  = (tab_c > W_EXT) ? W_C : tab_c[CW-1:0];
					res[n] = mk_res(KIND_CURSOR, '0, '0, '0, cur_of(nrow, ncol));
					n      = n + 2'd1;
				end
				CHAR_BACKSPACE: begin
					if (cur_of(nrow, ncol) > back_limit && ncol != '0) begin
						ncol   = ncol - CW'(1);
						res[n] = mk_res(KIND_WRITE, nrow, ncol, {text_color, CHAR_SPACE},
							cur_of(nrow, ncol));
						res[n + 2'd1] = mk_res(KIND_CURSOR, '0, '0, '0, cur_of(nrow, ncol));
						n      = n + 2'd2;
					end
				end
				default: begin
					res[n] = mk_res(KIND_WRITE, nrow, ncol, {text_color, char_code},
						cur_of(nrow, ncol + CW'(1)));
					ncol   = ncol + CW'(1);
					res[n + 2'd1] = mk_res(KIND_CURSOR, '0, '0, '0, cur_of(nrow, ncol));
					n      = n + 2'd2;
				end
			endcase
		end
		for (int i = 0; i < MAX_RESULTS; i++) begin
			res[i].last = (2'(i) == n - 2'd1) && (n != 2'd0);
		end
		row_next    = nrow;
		column_next = ncol;
		res_count   = n;
	end

endmodule

>>> hw/rtl/text_console_cursor_engine_core.sv
// text console cursor engine
// input stream: s_tdata carries a character byte, s_tuser selects put (0) or
// mark of the current cursor as backspace limit (1). one request is taken per
// cycle while the result buffer is empty or its final result leaves.
// output stream: zero to three results per request, m_tuser gives the kind (cell write,
// scroll up, cursor update), m_tlast flags the final result of an input.
// each input yields zero to three results; they appear in the cycle after the
// input is taken, one per cycle while m_tready is high.
// the next input is taken in the cycle its predecessor's last result is taken;
// the bound is the single output channel draining the three-entry buffer.
// stalling m_tready holds the current result and blocks new input.
// cfg_we writes the text color attribute; write it only while idle.
// reset clears cursor, backspace limit and buffer, and sets the color to 2.
module text_console_cursor_engine_core #(
	parameter int SCREEN_WIDTH  = 80,
	parameter int SCREEN_HEIGHT = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code
	input  logic [0:0]  s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // cell_row, cell_column, cell_value, cursor_position
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);
	import tcce_pkg::*;

	localparam int RW = $clog2(SCREEN_HEIGHT + 1);
	localparam int CW = $clog2(SCREEN_WIDTH + 1);

	logic [RW-1:0] row_q, row_next;
	logic [CW-1:0] col_q, col_next;
	logic [10:0]   lim_q, lim_next;
	logic [7:0]    color_q;
	res_t          buf_q [MAX_RESULTS];
	res_t          res_c [MAX_RESULTS];
	logic [1:0]    cnt_q, idx_q, res_count;
	res_t          head;
	logic          accept, pop;

	tcce_step #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.RW           (RW),
		.CW           (CW)
	) u_step (
		.func           (s_tuser[0]),
		.char_code      (s_tdata),
		.text_color     (color_q),
		.row            (row_q),
		.column         (col_q),
		.back_limit     (lim_q),
		.row_next       (row_next),
		.column_next    (col_next),
		.back_limit_next(lim_next),
		.res_count      (res_count),
		.res            (res_c)
	);

	assign head     = buf_q[idx_q];
	assign m_tvalid = idx_q < cnt_q;
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;
	assign m_tdata  = {1'b0, head.cursor_position, head.cell_value,
		head.cell_column, head.cell_row};
	assign pop      = m_tvalid && m_tready;
	assign s_tready = !m_tvalid || (m_tready && head.last);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			lim_q   <= '0;
			color_q <= COLOR_RESET;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			priority if (accept) begin
				row_q <= row_next;
				col_q <= col_next;
				lim_q <= lim_next;
				cnt_q <= res_count;
				idx_q <= '0;
			end else if (pop) begin
				if (head.last) begin
					cnt_q <= '0;
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q <= res_c;
		end
	end

endmodule

>>> hw/rtl/tcce_checker.sv
`include "text_console_cursor_engine_core_assert.svh"

module tcce_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import tcce_pkg::*;

	`TCCE_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
	`TCCE_ASSERT_VALID(a_write_not_last, m_tuser != KIND_WRITE || !m_tlast, "cell write flagged last")
	`TCCE_ASSERT_VALID(a_cursor_last, m_tuser != KIND_CURSOR || m_tlast, "cursor update not last")
	`TCCE_ASSERT_VALID(a_scroll_clean, m_tuser != KIND_SCROLL || m_tdata[27:0] == 28'd0, "scroll carries cell data")

endmodule

bind text_console_cursor_engine_core tcce_checker u_tcce_checker (.*);

>>> sim/console_result_checker.sv
module console_result_checker #(
	parameter int SCREEN_WIDTH  = 80,
	parameter int SCREEN_HEIGHT = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code
	input  logic [0:0]  s_tuser,   // func
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // cell_row, cell_column, cell_value, cursor_position
	input  logic [1:0]  m_tuser,   // kind
	input  logic        m_tlast,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output int          errors,
	output int          pending,
	output int          checked,
	output int          scrolls
);
	import tcce_pkg::*;

	int unsigned cur_row;
	int unsigned cur_col;
	logic [10:0] cur_index;
	logic [10:0] back_limit;
	logic [7:0]  text_color;
	res_t        cell_q[$];
	res_t        oldest;
	int          err_count = 0;
	int          result_count = 0;
	int          scroll_count = 0;

	assign errors  = err_count;
	assign checked = result_count;
	assign scrolls = scroll_count;

	function automatic logic [10:0] linear(int unsigned r, int unsigned c);
		return 11'(r * SCREEN_WIDTH + c);
	endfunction

	task automatic push_result(kind_t k, int unsigned r, int unsigned c, logic [15:0] v);
		res_t e;
		e.kind            = k;
		e.cell_row        = 5'(r);
		e.cell_column     = 7'(c);
		e.cell_value      = v;
		e.cursor_position = cur_index;
		e.last            = 1'b0;
		cell_q.push_back(e);
	endtask

	task automatic console_step(logic func, logic [7:0] ch);
		int          prior_size;
		int unsigned wr;
		int unsigned wc;
		res_t        e;
		prior_size = cell_q.size();
		if (func == FUNC_MARK) begin
			back_limit = cur_index;
			return;
		end
		// pending wrap, then pending scroll
		if (cur_col >= SCREEN_WIDTH) begin
			cur_col   = 0;
			cur_row   = cur_row + 1;
			cur_index = linear(cur_row, cur_col);
		end
		if (cur_row >= SCREEN_HEIGHT) begin
			cur_row   = SCREEN_HEIGHT - 1;
			cur_col   = 0;
			cur_index = linear(cur_row, cur_col);
			push_result(KIND_SCROLL, 0, 0, 16'h0);
		end
		if (ch == CHAR_NEWLINE) begin
			cur_col   = 0;
			cur_row   = cur_row + 1;
			cur_index = linear(cur_row, cur_col);
			push_result(KIND_CURSOR, 0, 0, 16'h0);
		end else if (ch == CHAR_TAB) begin
			cur_col = (cur_col & ~(TAB_STOP - 1)) + TAB_STOP;
			if (cur_col > SCREEN_WIDTH) begin
				cur_col = SCREEN_WIDTH;
			end
			cur_index = linear(cur_row, cur_col);
			push_result(KIND_CURSOR, 0, 0, 16'h0);
		end else if (ch == CHAR_BACKSPACE) begin
			if (cur_index > back_limit && cur_col > 0) begin
				cur_col   = cur_col - 1;
				cur_index = linear(cur_row, cur_col);
				push_result(KIND_WRITE, cur_row, cur_col, {text_color, CHAR_SPACE});
				push_result(KIND_CURSOR, 0, 0, 16'h0);
			end
		end else begin
			wr        = cur_row;
			wc        = cur_col;
			cur_col   = cur_col + 1;
			cur_index = linear(cur_row, cur_col);
			push_result(KIND_WRITE, wr, wc, {text_color, ch});
			push_result(KIND_CURSOR, 0, 0, 16'h0);
		end
		if (cell_q.size() > prior_size) begin
			e      = cell_q.pop_back();
			e.last = 1'b1;
			cell_q.push_back(e);
		end
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			err_count = err_count + 1;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row    = 0;
			cur_col    = 0;
			cur_index  = '0;
			back_limit = '0;
			text_color = COLOR_RESET;
			cell_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (cell_q.size() == 0) begin
					err_count = err_count + 1;
					$display("%0t: unexpected result, expected none, actual kind %0d data %h last %0d",
						$time, m_tuser, m_tdata, m_tlast);
				end else begin
					oldest = cell_q.pop_front();
					check_field("kind", oldest.kind, m_tuser);
					check_field("cell_row", oldest.cell_row, m_tdata[4:0]);
					check_field("cell_column", oldest.cell_column, m_tdata[11:5]);
					check_field("cell_value", oldest.cell_value, m_tdata[27:12]);
					check_field("cursor_position", oldest.cursor_position, m_tdata[38:28]);
					check_field("last", oldest.last, m_tlast);
					result_count = result_count + 1;
					if (oldest.kind == KIND_SCROLL) begin
						scroll_count = scroll_count + 1;
					end
				end
			end
			if (cfg_we) begin
				text_color = cfg_wdata;
			end
			if (s_tvalid && s_tready) begin
				console_step(s_tuser[0], s_tdata);
			end
		end
		pending = cell_q.size();
	end

endmodule

>>> sim/tb.sv
module tb;
	import tcce_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic [7:0]  s_tdata   = 8'h0;
	logic [0:0]  s_tuser   = 1'b0;
	logic        m_tready  = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [7:0]  cfg_wdata = 8'h0;
	logic        s_tready;
	logic        m_tvalid;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int errors;
	int pending;
	int checked;
	int scrolls;
	int sent = 0;
	int settings = 1;
	int idle_cycles = 0;
	bit s_calm = 1'b0;
	bit m_calm = 1'b0;
	int s_left = 0;
	int m_left = 0;

	text_console_cursor_engine_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	console_result_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked),
		.scrolls   (scrolls)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// calm stretches with no idling between busy ones
	function automatic int draw_wait(inout bit calm, inout int left);
		if (left == 0) begin
			calm = ($urandom_range(0, 2) == 0);
			left = $urandom_range(5, 40);
		end
		left = left - 1;
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	task automatic send(logic func, logic [7:0] ch);
		int gap;
		bit ok;
		gap = draw_wait(s_calm, s_left);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= ch;
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		sent = sent + 1;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_color(logic [7:0] c);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we    <= 1'b0;
		settings = settings + 1;
	endtask

	task automatic random_phase(int n);
		int target;
		target = sent + n;
		while (sent < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2: repeat ($urandom_range(1, 10)) send(FUNC_PUT, 8'($urandom_range(33, 126)));
				3: repeat ($urandom_range(1, 6)) send(FUNC_PUT, CHAR_NEWLINE);
				4: repeat ($urandom_range(1, 22)) send(FUNC_PUT, CHAR_TAB);
				5: begin
					send(FUNC_MARK, 8'($urandom));
					repeat ($urandom_range(0, 4)) send(FUNC_PUT, 8'($urandom_range(33, 126)));
					repeat ($urandom_range(1, 8)) send(FUNC_PUT, CHAR_BACKSPACE);
				end
				6: repeat ($urandom_range(1, 5)) send(FUNC_PUT, CHAR_BACKSPACE);
				7: send(FUNC_PUT, CHAR_SPACE);
				default: send(1'($urandom), 8'($urandom));
			endcase
		end
	endtask

	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			int  stall;
			bit  ok;
			stall = draw_wait(m_calm, m_left);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do begin
				@(negedge clk);
				ok = m_tvalid;
				@(posedge clk);
			end while (!ok);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] colors[5];
		colors = '{8'hFF, 8'h00, 8'h0F, 8'h80, 8'h00};
		colors[4] = 8'($urandom);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// backspace at column zero, byte extremes, limit not passed then passed
		send(FUNC_PUT, CHAR_BACKSPACE);
		send(FUNC_PUT, 8'h00);
		send(FUNC_PUT, 8'hFF);
		send(FUNC_MARK, 8'hFF);
		send(FUNC_PUT, CHAR_BACKSPACE);
		send(FUNC_PUT, 8'h41);
		send(FUNC_PUT, CHAR_BACKSPACE);
		// tabs up to the right edge, then newline out of a pending wrap
		repeat (20) send(FUNC_PUT, CHAR_TAB);
		send(FUNC_PUT, CHAR_NEWLINE);
		send(FUNC_MARK, 8'h00);

		foreach (colors[i]) begin
			write_color(colors[i]);
			random_phase(77);
		end
		settle();

		$display("Sent %0d requests under %0d color settings, checked %0d results (%0d scrolls)",
			sent, settings, checked, scrolls);
		if (errors == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> text_console_cursor_engine_core.f
+incdir+hw/rtl
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_step.sv
hw/rtl/text_console_cursor_engine_core.sv
hw/rtl/tcce_checker.sv
sim/console_result_checker.sv
sim/tb.sv
